// File: rtl/u128alu_pkg.sv
// Package with opcodes, widths and the pipeline payload type of the 128-bit arithmetic unit.
package u128alu_pkg;

    localparam int WORD_W  = 128;
    localparam int STEPS   = 128;
    localparam int OP_W    = 4;
    localparam int SHIFT_W = 8;
    localparam int IN_W    = 272;
    localparam int OUT_W   = 136;

    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV = 4'd3;
    localparam logic [OP_W-1:0] OP_MOD = 4'd4;
    localparam logic [OP_W-1:0] OP_AND = 4'd5;
    localparam logic [OP_W-1:0] OP_OR  = 4'd6;
    localparam logic [OP_W-1:0] OP_XOR = 4'd7;
    localparam logic [OP_W-1:0] OP_NOT = 4'd8;
    localparam logic [OP_W-1:0] OP_SHL = 4'd9;
    localparam logic [OP_W-1:0] OP_SHR = 4'd10;
    localparam logic [OP_W-1:0] OP_CMP = 4'd11;

    localparam logic [1:0] ORD_BELOW = 2'b11;
    localparam logic [1:0] ORD_EQUAL = 2'b00;
    localparam logic [1:0] ORD_ABOVE = 2'b01;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] q;
        logic [1:0]        order;
        logic              dz;
    } stage_t;

endpackage

// File: rtl/uint128_arithmetic_unit.sv
// Top level of the 128-bit unsigned arithmetic unit: entry stage, cell chain and output register.
// Each accepted transaction goes through the cell registers in order, then the output register.
// Throughput is one transaction per cycle while not held; the 128 cells advance as one pipeline.
// The whole chain holds while the output register is full and m_tready is low.
// Reset clears all valid flags; payload registers are not reset.
module uint128_arithmetic_unit
    import u128alu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // opcode, a_high, a_low, b_high, b_low, shift_amount, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // result_high, result_low, order, divide_by_zero, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    logic               en;
    logic [STEPS:0]     valid_chain;
    stage_t             stage_chain [STEPS+1];
    logic [OP_W-1:0]    in_op;
    logic [WORD_W-1:0]  in_a;
    logic [WORD_W-1:0]  in_b;
    logic [SHIFT_W-1:0] in_shift;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  result_reg;
    logic [WORD_W-1:0]  result_next;
    logic [1:0]         order_reg;
    logic               dz_reg;
    stage_t             last;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign in_op    = s_tdata[3:0];
    assign in_a     = {s_tdata[67:4], s_tdata[131:68]};
    assign in_b     = {s_tdata[195:132], s_tdata[259:196]};
    assign in_shift = s_tdata[267:260];

    u128alu_front front_i (
        .op           (in_op),
        .a            (in_a),
        .b            (in_b),
        .shift_amount (in_shift),
        .stage        (stage_chain[0])
    );

    assign valid_chain[0] = s_tvalid;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        u128alu_cell cell_i (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_chain[i]),
            .stage_in  (stage_chain[i]),
            .valid_out (valid_chain[i+1]),
            .stage_out (stage_chain[i+1])
        );
    end

    assign last = stage_chain[STEPS];

    always_comb
    begin
        if (last.dz)
            result_next = '0;
        else if (last.op == OP_MUL || last.op == OP_MOD)
            result_next = last.acc;
        else
            result_next = last.q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_chain[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            order_reg  <= last.order;
            dz_reg     <= last.dz;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, dz_reg, order_reg, result_reg[63:0], result_reg[127:64]};

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register state");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && dz_reg) |-> (result_reg == '0))
        else $error("divide by zero result is not zero");

    a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && order_reg != ORD_EQUAL) |-> (result_reg == '0 && !dz_reg))
        else $error("compare result carries a nonzero value");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output changed");

endmodule

// File: rtl/u128alu_front.sv
// Entry stage: decodes the transaction and combinationally computes the operations that need no cell steps.
module u128alu_front
    import u128alu_pkg::*;
(
    input  logic [OP_W-1:0]    op,
    input  logic [WORD_W-1:0]  a,
    input  logic [WORD_W-1:0]  b,
    input  logic [SHIFT_W-1:0] shift_amount,
    output stage_t             stage
);

    always_comb
    begin
        stage       = '0;
        stage.op    = op;
        stage.n     = a;
        stage.d     = b;
        stage.order = ORD_EQUAL;
        case (op)
            OP_ADD: stage.q = a + b;
            OP_SUB: stage.q = a - b;
            OP_AND: stage.q = a & b;
            OP_OR:  stage.q = a | b;
            OP_XOR: stage.q = a ^ b;
            OP_NOT: stage.q = ~a;
            OP_SHL: stage.q = a << shift_amount;
            OP_SHR: stage.q = a >> shift_amount;
            OP_CMP:
            begin
                if (a < b)
                    stage.order = ORD_BELOW;
                else if (a > b)
                    stage.order = ORD_ABOVE;
            end
            OP_DIV, OP_MOD: stage.dz = (b == '0);
            default: stage.q = '0;
        endcase
    end

endmodule

// File: rtl/u128alu_cell.sv
// One cell: restoring divide step, shift-and-add multiply step, or pass-through.
module u128alu_cell
    import u128alu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   valid_in,
    input  stage_t stage_in,
    output logic   valid_out,
    output stage_t stage_out
);

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W:0]   diff;

    always_comb
    begin
        stage_next = stage_in;
        shifted    = {stage_in.acc[WORD_W-2:0], stage_in.n[WORD_W-1]};
        diff       = {stage_in.acc[WORD_W-1], shifted} - {1'b0, stage_in.d};
        if (stage_in.op == OP_MUL)
        begin
            if (stage_in.d[0])
                stage_next.acc = stage_in.acc + stage_in.n;
            stage_next.n = {stage_in.n[WORD_W-2:0], 1'b0};
            stage_next.d = {1'b0, stage_in.d[WORD_W-1:1]};
        end
        else if (stage_in.op == OP_DIV || stage_in.op == OP_MOD)
        begin
            stage_next.n = {stage_in.n[WORD_W-2:0], 1'b0};
            if (!diff[WORD_W])
            begin
                stage_next.acc = diff[WORD_W-1:0];
                stage_next.q   = {stage_in.q[WORD_W-2:0], 1'b1};
            end
            else
            begin
                stage_next.acc = shifted;
                stage_next.q   = {stage_in.q[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule
